FILE: rtl/dbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbd_pkg: shared types and constants for the date difference pipeline
// Field widths, stage words and the calendar helper functions.
// ----------------------------------------------------------------------------
package dbd_pkg;

   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int OUT_W   = 23;
   localparam int DOY_W   = 9;
   localparam int PROD_W  = 25;
   localparam int QUOT_W  = 8;
   localparam int LEAP_W  = 12;
   localparam int FULL_W  = 23;
   localparam int SUM_W   = 25;

   // floor(m / 25) == (m * 5243) >> 17 for every 12-bit m
   localparam logic [12:0] RECIP_25 = 13'd5243;
   localparam int          RECIP_SH = 17;
   localparam logic [LEAP_W-1:0] QUARTER_CENTURY = 12'd25;

   localparam logic [DOY_W-1:0] DAYS_COMMON = 9'd365;
   localparam logic [DOY_W-1:0] DAYS_LEAP   = 9'd366;
   localparam logic [3:0]       IDX_FEB_DONE = 4'd2;
   localparam logic [3:0]       IDX_FULL_YEAR = 4'd12;

   typedef logic [YEAR_W-1:0]         year_type;
   typedef logic [PROD_W-1:0]         prod_type;
   typedef logic [DOY_W-1:0]          doy_type;
   typedef logic [LEAP_W-1:0]         leaps_type;
   typedef logic signed [SUM_W-1:0]   sum_type;

   localparam sum_type SUM_NEG1 = '1;
   localparam sum_type OUT_MAX  = 25'sd4194303;

   typedef struct packed {
      year_type            since_year;
      logic [MONTH_W-1:0]  since_month;
      logic [DAY_W-1:0]    since_day;
      year_type            till_year;
      logic [MONTH_W-1:0]  till_month;
      logic [DAY_W-1:0]    till_day;
   } req_type;

   typedef struct packed {
      year_type          y1;
      year_type          y2;
      year_type          y2m1;
      prod_type          prod1;
      prod_type          prod2;
      prod_type          prod2m1;
      logic [3:0]        bef1;
      logic [3:0]        bef2;
      logic [DAY_W-1:0]  d1;
      logic [DAY_W-1:0]  d2;
      year_type          yspan;
      logic              same_year;
      logic              later_year;
   } s1_type;

   typedef struct packed {
      doy_type            doy1;
      doy_type            doy2;
      doy_type            len1;
      leaps_type          lp1;
      leaps_type          lp2m1;
      logic [FULL_W-1:0]  full_days;
      logic               same_year;
      logic               later_year;
   } s2_type;

   typedef struct packed {
      sum_type  between;
      sum_type  part;
      sum_type  same_res;
      logic     same_year;
      logic     later_year;
   } s3_type;

   // Days in the months before month index (0..12), common year
   function automatic doy_type cum_days(input logic [3:0] idx);
      doy_type r;
      case (idx)
         4'd0:    r = 9'd0;
         4'd1:    r = 9'd31;
         4'd2:    r = 9'd59;
         4'd3:    r = 9'd90;
         4'd4:    r = 9'd120;
         4'd5:    r = 9'd151;
         4'd6:    r = 9'd181;
         4'd7:    r = 9'd212;
         4'd8:    r = 9'd243;
         4'd9:    r = 9'd273;
         4'd10:   r = 9'd304;
         4'd11:   r = 9'd334;
         default: r = 9'd365;
      endcase
      return r;
   endfunction

   // Quotient y / 100 from the registered reciprocal product of y / 4
   function automatic logic [QUOT_W-1:0] cent_quot(input prod_type prod);
      return prod[PROD_W-1:RECIP_SH];
   endfunction

   function automatic logic leap_year(input year_type y, input prod_type prod);
      logic [QUOT_W-1:0] q;
      logic              div100;
      q      = cent_quot(prod);
      div100 = (y[YEAR_W-1:2] == LEAP_W'(q) * QUARTER_CENTURY);
      return (y[1:0] == 2'b00) && (!div100 || (q[1:0] == 2'b00));
   endfunction

   // Leap years among 1..y: y/4 - y/100 + y/400
   function automatic leaps_type leaps_upto(input year_type y, input prod_type prod);
      logic [QUOT_W-1:0] q;
      q = cent_quot(prod);
      return LEAP_W'(y[YEAR_W-1:2]) - LEAP_W'(q) + LEAP_W'(q[QUOT_W-1:2]);
   endfunction

endpackage

FILE: rtl/days_between_dates_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// days_between_dates_core: Gregorian date difference in days
// Four-stage pipeline from a since/till date pair to a signed day count.
//
//   channel  direction  ports                               handshake
//   req      in         req_since_*, req_till_*             req_valid / req_stall
//   rsp      out        rsp_day_count                       rsp_valid / rsp_stall
//
// One word enters per cycle while req_stall is low; four register stages
// (prep, year days, span, result) carry each word through to its result on rsp.
// A stall on rsp holds the full stages; empty stages keep filling, so
// req_stall rises only when all four stages hold a word.
// Reset clears the stage valid bits only; no clearing pass is needed.
// ----------------------------------------------------------------------------
module days_between_dates_core #(
   parameter int MAX_YEAR = 9999
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [dbd_pkg::YEAR_W-1:0]         req_since_year,
   input  logic [dbd_pkg::MONTH_W-1:0]        req_since_month,
   input  logic [dbd_pkg::DAY_W-1:0]          req_since_day,
   input  logic [dbd_pkg::YEAR_W-1:0]         req_till_year,
   input  logic [dbd_pkg::MONTH_W-1:0]        req_till_month,
   input  logic [dbd_pkg::DAY_W-1:0]          req_till_day,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [dbd_pkg::OUT_W-1:0]   rsp_day_count
);

   dbd_pkg::req_type req;
   dbd_pkg::s1_type  s1;
   dbd_pkg::s2_type  s2;
   dbd_pkg::s3_type  s3;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic en1, en2, en3, en4;

   assign req.since_year  = req_since_year;
   assign req.since_month = req_since_month;
   assign req.since_day   = req_since_day;
   assign req.till_year   = req_till_year;
   assign req.till_month  = req_till_month;
   assign req.till_day    = req_till_day;

   // advance a stage when it is empty or its word moves on
   assign en4 = !v4_ff || !rsp_stall;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign v1_in = en1 ? req_valid : v1_ff;
   assign v2_in = en2 ? v1_ff : v2_ff;
   assign v3_in = en3 ? v2_ff : v3_ff;
   assign v4_in = en4 ? v3_ff : v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   assign req_stall = !en1;
   assign rsp_valid = v4_ff;

   dbd_prep #(
      .MAX_YEAR (MAX_YEAR)
   ) u_prep (
      .clock (clock),
      .load  (en1),
      .req   (req),
      .s1_ff (s1)
   );

   dbd_yeardays u_yeardays (
      .clock (clock),
      .load  (en2),
      .s1    (s1),
      .s2_ff (s2)
   );

   dbd_span u_span (
      .clock (clock),
      .load  (en3),
      .s2    (s2),
      .s3_ff (s3)
   );

   dbd_result u_result (
      .clock        (clock),
      .load         (en4),
      .s3           (s3),
      .day_count_ff (rsp_day_count)
   );

`ifndef NO_ASSERTIONS
   a_no_stall_free_out: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled while output drains");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v1_ff && v2_ff && v3_ff && v4_ff))
      else $error("input stalled with an empty stage");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> v1_ff)
      else $error("accepted word missing from first stage");

   a_last_to_out: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && en4) |=> rsp_valid)
      else $error("word lost between span and result stages");
`endif

endmodule

FILE: rtl/dbd_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbd_prep: first stage
// Clamps the years, compares them, maps months to table indexes and starts the
// divide-by-100 reciprocal multiplies.
// ----------------------------------------------------------------------------
module dbd_prep #(
   parameter int MAX_YEAR = 9999
) (
   input  logic            clock,
   input  logic            load,
   input  dbd_pkg::req_type req,
   output dbd_pkg::s1_type  s1_ff
);

   dbd_pkg::s1_type  s1_in;
   dbd_pkg::year_type y1, y2;

   function automatic dbd_pkg::year_type clamp(input dbd_pkg::year_type y);
      return (int'(y) > MAX_YEAR) ? dbd_pkg::YEAR_W'(MAX_YEAR) : y;
   endfunction

   function automatic logic [3:0] month_idx(input logic [dbd_pkg::MONTH_W-1:0] m);
      logic [3:0] r;
      if (m == '0) begin
         r = '0;
      end else if (m > dbd_pkg::IDX_FULL_YEAR) begin
         r = dbd_pkg::IDX_FULL_YEAR;
      end else begin
         r = m - 4'd1;
      end
      return r;
   endfunction

   function automatic dbd_pkg::prod_type recip(input dbd_pkg::year_type y);
      return dbd_pkg::PROD_W'(y[dbd_pkg::YEAR_W-1:2])
           * dbd_pkg::PROD_W'(dbd_pkg::RECIP_25);
   endfunction

   always_comb begin
      y1 = clamp(req.since_year);
      y2 = clamp(req.till_year);
      s1_in.y1         = y1;
      s1_in.y2         = y2;
      s1_in.y2m1       = y2 - dbd_pkg::YEAR_W'(1);
      s1_in.prod1      = recip(y1);
      s1_in.prod2      = recip(y2);
      s1_in.prod2m1    = recip(y2 - dbd_pkg::YEAR_W'(1));
      s1_in.bef1       = month_idx(req.since_month);
      s1_in.bef2       = month_idx(req.till_month);
      s1_in.d1         = req.since_day;
      s1_in.d2         = req.till_day;
      s1_in.yspan      = y2 - y1 - dbd_pkg::YEAR_W'(1);
      s1_in.same_year  = (y1 == y2);
      s1_in.later_year = (y2 > y1);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_ff <= s1_in;
      end
   end

endmodule

FILE: rtl/dbd_yeardays.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbd_yeardays: second stage
// Leap flags, day of year for both dates, leap counts and the full-year span.
// ----------------------------------------------------------------------------
module dbd_yeardays (
   input  logic            clock,
   input  logic            load,
   input  dbd_pkg::s1_type s1,
   output dbd_pkg::s2_type s2_ff
);

   dbd_pkg::s2_type s2_in;
   logic            leap1, leap2;

   always_comb begin
      leap1 = dbd_pkg::leap_year(s1.y1, s1.prod1);
      leap2 = dbd_pkg::leap_year(s1.y2, s1.prod2);
      s2_in.doy1 = dbd_pkg::cum_days(s1.bef1)
                 + dbd_pkg::DOY_W'(leap1 && (s1.bef1 >= dbd_pkg::IDX_FEB_DONE))
                 + dbd_pkg::DOY_W'(s1.d1);
      s2_in.doy2 = dbd_pkg::cum_days(s1.bef2)
                 + dbd_pkg::DOY_W'(leap2 && (s1.bef2 >= dbd_pkg::IDX_FEB_DONE))
                 + dbd_pkg::DOY_W'(s1.d2);
      s2_in.len1       = leap1 ? dbd_pkg::DAYS_LEAP : dbd_pkg::DAYS_COMMON;
      s2_in.lp1        = dbd_pkg::leaps_upto(s1.y1, s1.prod1);
      s2_in.lp2m1      = dbd_pkg::leaps_upto(s1.y2m1, s1.prod2m1);
      s2_in.full_days  = dbd_pkg::FULL_W'(s1.yspan)
                       * dbd_pkg::FULL_W'(dbd_pkg::DAYS_COMMON);
      s2_in.same_year  = s1.same_year;
      s2_in.later_year = s1.later_year;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s2_ff <= s2_in;
      end
   end

endmodule

FILE: rtl/dbd_span.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbd_span: third stage
// Days in the whole years between, days across the year edges, and the
// same-year difference.
// ----------------------------------------------------------------------------
module dbd_span (
   input  logic            clock,
   input  logic            load,
   input  dbd_pkg::s2_type s2,
   output dbd_pkg::s3_type s3_ff
);

   dbd_pkg::s3_type s3_in;

   always_comb begin
      s3_in.between = dbd_pkg::sum_type'(s2.full_days)
                    + dbd_pkg::sum_type'(s2.lp2m1)
                    - dbd_pkg::sum_type'(s2.lp1);
      // days left in the since year plus days gone in the till year
      s3_in.part    = dbd_pkg::sum_type'(s2.len1)
                    - dbd_pkg::sum_type'(s2.doy1)
                    + dbd_pkg::sum_type'(s2.doy2);
      s3_in.same_res = (s2.doy2 >= s2.doy1)
                     ? dbd_pkg::sum_type'(s2.doy2) - dbd_pkg::sum_type'(s2.doy1)
                     : dbd_pkg::SUM_NEG1;
      s3_in.same_year  = s2.same_year;
      s3_in.later_year = s2.later_year;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s3_ff <= s3_in;
      end
   end

endmodule

FILE: rtl/dbd_result.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbd_result: last stage
// Final add, case select and saturation into the output register.
// ----------------------------------------------------------------------------
module dbd_result (
   input  logic                               clock,
   input  logic                               load,
   input  dbd_pkg::s3_type                    s3,
   output logic signed [dbd_pkg::OUT_W-1:0]   day_count_ff
);

   dbd_pkg::sum_type                  res;
   logic signed [dbd_pkg::OUT_W-1:0]  day_count_in;

   always_comb begin
      if (s3.later_year) begin
         res = s3.between + s3.part;
      end else if (s3.same_year) begin
         res = s3.same_res;
      end else begin
         res = dbd_pkg::SUM_NEG1;
      end
      if (res > dbd_pkg::OUT_MAX) begin
         res = dbd_pkg::OUT_MAX;
      end
      day_count_in = res[dbd_pkg::OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         day_count_ff <= day_count_in;
      end
   end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the date difference pipeline
// A table of directed date pairs comes first: same day, reversed order,
// leap and century years, out-of-range months, year zero and clamped years.
// About two thousand random pairs follow. Each expected day count comes from
// a calendar predictor, or from the table where the answer is obvious.
// Both channels idle at random, and one long result stall fills the pipe.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int    CAL_MAX_YEAR   = 9999;
   localparam int    RANDOM_PAIRS   = 2000;
   localparam int    WATCHDOG_LIMIT = 4000;
   localparam int    DRAIN_CYCLES   = 12;
   localparam int    HOLD_OFF_LEN   = 120;
   localparam longint DAY_COUNT_MAX = 4194303;
   localparam int    MONTH_START [13] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
                                          304, 334, 365};

   typedef logic signed [dbd_pkg::OUT_W-1:0] day_count_type;

   typedef struct packed {
      int sy;
      int sm;
      int sd;
      int ty;
      int tm;
      int td;
      bit known;
      int days;
   } date_case_type;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic [dbd_pkg::YEAR_W-1:0]   req_since_year;
   logic [dbd_pkg::MONTH_W-1:0]  req_since_month;
   logic [dbd_pkg::DAY_W-1:0]    req_since_day;
   logic [dbd_pkg::YEAR_W-1:0]   req_till_year;
   logic [dbd_pkg::MONTH_W-1:0]  req_till_month;
   logic [dbd_pkg::DAY_W-1:0]    req_till_day;
   logic                         rsp_valid;
   logic                         rsp_stall;
   day_count_type                rsp_day_count;

   day_count_type expected_days[$];
   int            mismatches;
   int            words_sent;
   int            words_checked;
   bit            quiet;
   bit            hold_off;
   bit            hold_off_done;

   date_case_type directed_cases [22] = '{
      '{2000,  1,  1, 2000,  1,  1, 1'b1,       0},
      '{2000,  3,  1, 2000,  2, 28, 1'b1,      -1},
      '{2001,  1,  1, 2000, 12, 31, 1'b1,      -1},
      '{   1,  1,  1, 9999, 12, 31, 1'b1, 3652058},
      '{2000,  2, 28, 2000,  3,  1, 1'b1,       2},
      '{1900,  2, 28, 1900,  3,  1, 1'b1,       1},
      '{2004,  2, 28, 2004,  3,  1, 1'b1,       2},
      '{2023, 12, 31, 2024,  1,  1, 1'b1,       1},
      '{   1,  1,  1,    2,  1,  1, 1'b1,     365},
      '{1999, 12, 31, 2000, 12, 31, 1'b1,     366},
      '{9998, 12, 31, 9999,  1,  1, 1'b1,       1},
      '{16383, 1,  1, 12000, 1,  1, 1'b1,       0},
      '{9999, 12, 31, 16383, 12, 31, 1'b1,      0},
      '{16383, 15, 31,   0,  0,  0, 1'b1,      -1},
      '{2020,  0,  5, 2020,  1,  1, 1'b0,       0},
      '{2020, 13,  0, 2020, 15, 31, 1'b0,       0},
      '{2019, 15, 31, 2020,  0,  0, 1'b0,       0},
      '{   0,  1,  1,    1,  1,  1, 1'b0,       0},
      '{   0,  0,  0, 16383, 15, 31, 1'b0,      0},
      '{2021,  2, 31, 2021,  3,  0, 1'b0,       0},
      '{ 399,  3,  1,  401,  3,  1, 1'b0,       0},
      '{1600,  2, 29, 2400,  2, 29, 1'b0,       0}
   };

   days_between_dates_core #(
      .MAX_YEAR (CAL_MAX_YEAR)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_since_year  (req_since_year),
      .req_since_month (req_since_month),
      .req_since_day   (req_since_day),
      .req_till_year   (req_till_year),
      .req_till_month  (req_till_month),
      .req_till_day    (req_till_day),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_day_count   (rsp_day_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------- calendar
   function automatic bit is_leap(input longint y);
      if (y % 4 != 0) return 1'b0;
      if (y % 100 != 0) return 1'b1;
      return (y % 400) == 0;
   endfunction

   // leap years among 1..n
   function automatic longint leap_count(input longint n);
      return n / 4 - n / 100 + n / 400;
   endfunction

   function automatic longint clamp_year(input logic [dbd_pkg::YEAR_W-1:0] y);
      return (longint'(y) > CAL_MAX_YEAR) ? CAL_MAX_YEAR : longint'(y);
   endfunction

   function automatic longint day_of_year(input longint y,
                                          input logic [dbd_pkg::MONTH_W-1:0] m,
                                          input logic [dbd_pkg::DAY_W-1:0] d);
      int     prior;
      longint days;
      // month 0 counts nothing, 13..15 count the whole year
      prior = (m == 0) ? 0 : ((m > 13) ? 12 : int'(m) - 1);
      days  = MONTH_START[prior];
      if (prior >= 2 && is_leap(y)) days++;
      return days + longint'(d);
   endfunction

   function automatic day_count_type predict_day_count(input dbd_pkg::req_type w);
      longint y1, y2, doy1, doy2, span;
      y1   = clamp_year(w.since_year);
      y2   = clamp_year(w.till_year);
      doy1 = day_of_year(y1, w.since_month, w.since_day);
      doy2 = day_of_year(y2, w.till_month, w.till_day);
      span = -1;
      if (y1 == y2) begin
         if (doy2 >= doy1) span = doy2 - doy1;
      end else if (y2 > y1) begin
         span = (is_leap(y1) ? 366 : 365) - doy1 + 365 * (y2 - y1 - 1)
              + leap_count(y2 - 1) - leap_count(y1) + doy2;
      end
      if (span > DAY_COUNT_MAX) span = DAY_COUNT_MAX;
      return span[dbd_pkg::OUT_W-1:0];
   endfunction

   // ---------------------------------------------------------------- stimulus
   // mostly zero, some short gaps, a few long ones
   function automatic int unsigned idle_len();
      int unsigned r;
      if (quiet) return 0;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic dbd_pkg::req_type random_pair();
      dbd_pkg::req_type w;
      int unsigned      pick;
      int unsigned      sy, ty, swap;
      pick = $urandom_range(99);
      if (pick < 15) begin
         // raw field values, every bit free
         w.since_year  = dbd_pkg::YEAR_W'($urandom_range(16383));
         w.since_month = dbd_pkg::MONTH_W'($urandom_range(15));
         w.since_day   = dbd_pkg::DAY_W'($urandom_range(31));
         w.till_year   = dbd_pkg::YEAR_W'($urandom_range(16383));
         w.till_month  = dbd_pkg::MONTH_W'($urandom_range(15));
         w.till_day    = dbd_pkg::DAY_W'($urandom_range(31));
      end else begin
         sy = $urandom_range(1, CAL_MAX_YEAR);
         if ($urandom_range(99) < 40) begin
            ty = sy + $urandom_range(0, 2);
            if (ty > CAL_MAX_YEAR) ty = CAL_MAX_YEAR;
         end else begin
            ty = $urandom_range(1, CAL_MAX_YEAR);
         end
         // keep most pairs in order; the rest may run backwards
         if (pick < 85 && ty < sy) begin
            swap = sy;
            sy   = ty;
            ty   = swap;
         end
         w.since_year  = dbd_pkg::YEAR_W'(sy);
         w.since_month = dbd_pkg::MONTH_W'($urandom_range(1, 12));
         w.since_day   = dbd_pkg::DAY_W'($urandom_range(1, 31));
         w.till_year   = dbd_pkg::YEAR_W'(ty);
         w.till_month  = dbd_pkg::MONTH_W'($urandom_range(1, 12));
         w.till_day    = dbd_pkg::DAY_W'($urandom_range(1, 31));
      end
      return w;
   endfunction

   task automatic offer_word(input dbd_pkg::req_type w, input day_count_type days);
      int unsigned gap;
      req_valid       <= 1'b1;
      req_since_year  <= w.since_year;
      req_since_month <= w.since_month;
      req_since_day   <= w.since_day;
      req_till_year   <= w.till_year;
      req_till_month  <= w.till_month;
      req_till_day    <= w.till_day;
      do @(posedge clock); while (req_stall);
      expected_days.push_back(days);
      words_sent++;
      gap = hold_off ? 0 : idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic report_mismatch(input string what);
      if (mismatches < 50) $display("mismatch: %s", what);
      mismatches++;
   endtask

   // ---------------------------------------------------------------- sequence
   initial begin
      dbd_pkg::req_type w;
      day_count_type    days;
      mismatches      = 0;
      words_sent      = 0;
      words_checked   = 0;
      quiet           = 1'b0;
      hold_off        = 1'b0;
      hold_off_done   = 1'b0;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_since_year  <= '0;
      req_since_month <= '0;
      req_since_day   <= '0;
      req_till_year   <= '0;
      req_till_month  <= '0;
      req_till_day    <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_cases[i]) begin
         w.since_year  = dbd_pkg::YEAR_W'(directed_cases[i].sy);
         w.since_month = dbd_pkg::MONTH_W'(directed_cases[i].sm);
         w.since_day   = dbd_pkg::DAY_W'(directed_cases[i].sd);
         w.till_year   = dbd_pkg::YEAR_W'(directed_cases[i].ty);
         w.till_month  = dbd_pkg::MONTH_W'(directed_cases[i].tm);
         w.till_day    = dbd_pkg::DAY_W'(directed_cases[i].td);
         days = directed_cases[i].known ? dbd_pkg::OUT_W'(directed_cases[i].days)
                                        : predict_day_count(w);
         offer_word(w, days);
      end

      for (int n = 0; n < RANDOM_PAIRS; n++) begin
         // every fourth block runs back to back
         quiet = ((n / 200) % 4) == 1;
         w = random_pair();
         offer_word(w, predict_day_count(w));
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      while (expected_days.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // ---------------------------------------------------------------- receiver
   initial begin
      int unsigned n_stall;
      rsp_stall <= 1'b0;
      @(negedge reset);
      @(posedge clock);
      forever begin
         if (!hold_off_done && words_sent >= 500) begin
            // long hold-off while the sender keeps offering
            hold_off_done = 1'b1;
            hold_off      = 1'b1;
            n_stall       = HOLD_OFF_LEN;
         end else begin
            n_stall = idle_len();
         end
         if (n_stall > 0) begin
            rsp_stall <= 1'b1;
            repeat (n_stall) @(posedge clock);
         end
         hold_off = 1'b0;
         rsp_stall <= 1'b0;
         repeat (1 + $urandom_range(0, 6)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      day_count_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_days.size() == 0) begin
            report_mismatch($sformatf("day_count %0d with no word outstanding",
                                      rsp_day_count));
         end else begin
            want = expected_days.pop_front();
            if (rsp_day_count !== want)
               report_mismatch($sformatf("word %0d: day_count %0d, expected %0d",
                                         words_checked, rsp_day_count, want));
         end
         words_checked++;
      end
   end

   // ---------------------------------------------------------------- watchdog
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
   end

endmodule
